// File: rtl/tlvp_pkg.sv
package tlvp_pkg;

  localparam int ByteW = 8;
  localparam int CountW = 7;
  localparam int WordW = 32;
  localparam int SizeW = 2;
  localparam int WordIdxW = 6;

  localparam logic [CountW-1:0] HeaderReset = 7'd9;
  localparam logic [CountW-1:0] CountMax = 7'd127;
  localparam logic [ByteW-1:0] LenMask = 8'h3F;

  // size codes of the size/length byte
  localparam logic [SizeW-1:0] SzByte = 2'd0;
  localparam logic [SizeW-1:0] SzHalf = 2'd1;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             frame_end;
  } beat_t;

  typedef struct packed {
    logic [CountW-1:0]   element_index;
    logic [ByteW-1:0]    element_id;
    logic [SizeW-1:0]    word_size;
    logic [WordIdxW-1:0] word_index;
    logic [WordW-1:0]    word_value;
    logic                last_word;
    logic                status;
  } result_t;

  // handshake between the parse stage and the output register
  typedef struct packed {
    logic advance;
  } step_ctl_t;

endpackage

// File: rtl/tlvp_if.sv
interface tlvp_in_if;
  logic                      valid;
  logic                      ready;
  logic [tlvp_pkg::ByteW-1:0] byte_value;
  logic                      frame_end;

  modport source (output valid, output byte_value, output frame_end, input ready);
  modport sink (input valid, input byte_value, input frame_end, output ready);
endinterface

interface tlvp_out_if;
  logic                         valid;
  logic                         ready;
  logic [tlvp_pkg::CountW-1:0]   element_index;
  logic [tlvp_pkg::ByteW-1:0]    element_id;
  logic [tlvp_pkg::SizeW-1:0]    word_size;
  logic [tlvp_pkg::WordIdxW-1:0] word_index;
  logic [tlvp_pkg::WordW-1:0]    word_value;
  logic                         last_word;
  logic                         status;

  modport source (output valid, output element_index, output element_id, output word_size,
                  output word_index, output word_value, output last_word, output status,
                  input ready);
  modport sink (input valid, input element_index, input element_id, input word_size,
                input word_index, input word_value, input last_word, input status,
                output ready);
endinterface

interface tlvp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tlvp_pkg::CountW-1:0] header_bytes;

  modport source (output valid, output header_bytes, input ready);
  modport sink (input valid, input header_bytes, output ready);
endinterface

// File: rtl/tlvp_in_reg.sv
module tlvp_in_reg (
  input  logic              clk,
  input  logic              rst,
  tlvp_in_if.sink           frame,
  input  logic              advance,
  output logic              beat_valid,
  output tlvp_pkg::beat_t   beat
);

  logic valid;

  assign frame.ready = !valid || advance;
  assign beat_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (frame.ready) begin
      valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      beat.byte_value <= frame.byte_value;
      beat.frame_end <= frame.frame_end;
    end
  end

endmodule

// File: rtl/tlvp_step.sv
module tlvp_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tlvp_pkg::CountW-1:0] header_bytes,
  input  tlvp_pkg::beat_t             beat,
  input  logic                        advance,
  output logic                        res_valid,
  output tlvp_pkg::result_t           res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ID,
    PH_SIZE,
    PH_DATA
  } phase_t;

  phase_t                          phase, phase_next;
  logic [tlvp_pkg::CountW-1:0]     skip_count, skip_count_next;
  logic [tlvp_pkg::ByteW-1:0]      current_id, current_id_next;
  logic [tlvp_pkg::SizeW-1:0]      current_size, current_size_next;
  logic [tlvp_pkg::CountW-1:0]     words_left, words_left_next;
  logic [tlvp_pkg::WordIdxW-1:0]   word_position, word_position_next;
  logic [1:0]                      byte_in_word, byte_in_word_next;
  logic [tlvp_pkg::WordW-1:0]      word_accumulator, word_accumulator_next;
  logic [tlvp_pkg::CountW-1:0]     element_count, element_count_next;
  logic [tlvp_pkg::WordW-1:0]      acc_shift;
  logic                            word_done;
  logic                            take_id;
  logic                            is_last;

  always_comb begin
    acc_shift = {word_accumulator[tlvp_pkg::WordW-tlvp_pkg::ByteW-1:0], beat.byte_value};
    case (current_size)
      tlvp_pkg::SzByte: word_done = 1'b1;
      tlvp_pkg::SzHalf: word_done = (byte_in_word == 2'd1);
      default:          word_done = (byte_in_word == 2'd3);
    endcase
    is_last = (words_left <= 7'd1);
    take_id = (phase == PH_ID) || (phase == PH_HEADER && !(skip_count < header_bytes));

    phase_next = phase;
    skip_count_next = skip_count;
    current_id_next = current_id;
    current_size_next = current_size;
    words_left_next = words_left;
    word_position_next = word_position;
    byte_in_word_next = byte_in_word;
    word_accumulator_next = word_accumulator;
    element_count_next = element_count;
    res_valid = 1'b0;
    res = '0;

    if (take_id) begin
      current_id_next = beat.byte_value;
      current_size_next = tlvp_pkg::SzByte;
      phase_next = PH_SIZE;
    end else if (phase == PH_HEADER) begin
      skip_count_next = skip_count + 7'd1;
    end else if (phase == PH_SIZE) begin
      current_size_next = beat.byte_value[7:6];
      words_left_next = {1'b0, beat.byte_value[5:0] & tlvp_pkg::LenMask[5:0]} + 7'd1;
      word_position_next = '0;
      byte_in_word_next = '0;
      word_accumulator_next = '0;
      phase_next = PH_DATA;
    end else begin
      if (word_done) begin
        res_valid = 1'b1;
        res.element_index = element_count;
        res.element_id = current_id;
        res.word_size = current_size;
        res.word_index = word_position;
        res.word_value = acc_shift;
        res.last_word = is_last;
        res.status = 1'b0;
        byte_in_word_next = '0;
        word_accumulator_next = '0;
        word_position_next = word_position + 6'd1;
        words_left_next = (words_left != '0) ? words_left - 7'd1 : '0;
        if (is_last) begin
          phase_next = PH_ID;
          if (element_count < tlvp_pkg::CountMax) begin
            element_count_next = element_count + 7'd1;
          end
        end
      end else begin
        byte_in_word_next = byte_in_word + 2'd1;
        word_accumulator_next = acc_shift;
      end
    end

    if (beat.frame_end) begin
      if (res_valid) begin
        // frame cut right after a word that was not the last one
        if (phase_next == PH_DATA) res.status = 1'b1;
      end else if (phase_next == PH_SIZE || phase_next == PH_DATA) begin
        res_valid = 1'b1;
        res.element_index = element_count_next;
        res.element_id = current_id_next;
        res.word_size = (phase_next == PH_DATA) ? current_size_next : tlvp_pkg::SzByte;
        res.word_index = (phase_next == PH_DATA) ? word_position_next : '0;
        res.word_value = (phase_next == PH_DATA) ? word_accumulator_next : '0;
        res.last_word = 1'b0;
        res.status = 1'b1;
      end
      phase_next = PH_HEADER;
      skip_count_next = '0;
      element_count_next = '0;
      words_left_next = '0;
      word_position_next = '0;
      byte_in_word_next = '0;
      word_accumulator_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      skip_count <= '0;
      current_id <= '0;
      current_size <= '0;
      words_left <= '0;
      word_position <= '0;
      byte_in_word <= '0;
      word_accumulator <= '0;
      element_count <= '0;
    end else if (advance) begin
      phase <= phase_next;
      skip_count <= skip_count_next;
      current_id <= current_id_next;
      current_size <= current_size_next;
      words_left <= words_left_next;
      word_position <= word_position_next;
      byte_in_word <= byte_in_word_next;
      word_accumulator <= word_accumulator_next;
      element_count <= element_count_next;
    end
  end

endmodule

// File: rtl/tlvp_out_reg.sv
module tlvp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat_valid,
  input  logic                res_valid,
  input  tlvp_pkg::result_t   res,
  output tlvp_pkg::step_ctl_t ctl,
  tlvp_out_if.source          result
);

  logic              valid;
  tlvp_pkg::result_t data;
  logic              space;
  logic              load;

  // a beat that yields no result never waits on the output side
  assign space = !valid || result.ready;
  assign ctl.advance = beat_valid && (!res_valid || space);
  assign load = ctl.advance && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign result.valid = valid;
  assign result.element_index = data.element_index;
  assign result.element_id = data.element_id;
  assign result.word_size = data.word_size;
  assign result.word_index = data.word_index;
  assign result.word_value = data.word_value;
  assign result.last_word = data.last_word;
  assign result.status = data.status;

endmodule

// File: rtl/tlv_payload_parser.sv
// byte-serial parser for received frames made of a mac header and tlv elements.
// frame: one byte per beat, frame_end high on the last byte of each frame.
// result: one beat per completed data word (element index, id, size code,
//   word index, big-endian value, last_word); status 1 marks a frame that
//   ended inside an element, carrying the partial word.
// cfg: header_bytes, the number of header bytes skipped at the start of
//   every frame; always ready, write it only while the parser is idle.
// path: a byte that completes a word passes the input register, then the
//   result register, on its way from frame to result.
// throughput: one byte per cycle while result is not stalled; the per-byte
//   state update is a single level of logic between input and result register.
// reset: header_bytes returns to 9 and parsing restarts in header skip.
// a stalled result holds; frame keeps taking bytes until a byte that yields
//   a result meets a full result register, and bytes with no result pass on.
module tlv_payload_parser (
  input  logic       clk,
  input  logic       rst,
  tlvp_in_if.sink    frame,
  tlvp_out_if.source result,
  tlvp_cfg_if.sink   cfg
);

  logic [tlvp_pkg::CountW-1:0] header_bytes;
  logic                        beat_valid;
  tlvp_pkg::beat_t             beat;
  tlvp_pkg::step_ctl_t         ctl;
  tlvp_pkg::result_t           res;
  logic                        res_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= tlvp_pkg::HeaderReset;
    end else if (cfg.valid && cfg.ready) begin
      header_bytes <= cfg.header_bytes;
    end
  end

  tlvp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame),
    .advance    (ctl.advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  tlvp_step u_step (
    .clk          (clk),
    .rst          (rst),
    .header_bytes (header_bytes),
    .beat         (beat),
    .advance      (ctl.advance),
    .res_valid    (res_valid),
    .res          (res)
  );

  tlvp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .res_valid  (res_valid),
    .res        (res),
    .ctl        (ctl),
    .result     (result)
  );

endmodule
